// ----- rtl/mtc_pkg.sv -----
// ============================================================================
// mtc_pkg
// Shared types, sizes and codes of the multiple-tau correlator.
// ============================================================================
package mtc_pkg;

  localparam int LEVELS       = 20;
  localparam int LAGS         = 16;
  localparam int SAMPLE_WIDTH = 24;
  localparam int SLOTS        = LEVELS * LAGS;

  localparam int LEVEL_W = 5;
  localparam int LAG_W   = 4;
  localparam int ADDR_W  = LEVEL_W + LAG_W;
  localparam int LSUM_W  = 27;
  localparam int PROD_W  = 2 * SAMPLE_WIDTH;
  localparam int PSUM_W  = 64;
  localparam int CNT_W   = 32;
  localparam int MEAN_W  = 48;
  localparam int TIME_W  = 61;

  // operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // configuration register indexes
  localparam logic CFG_MODE      = 1'b0;
  localparam logic CFG_AVG_SHIFT = 1'b1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [PSUM_W-1:0]       psum_t;

  // saturating add of a product onto a 64-bit sum
  function automatic psum_t sat_add(input psum_t a, input prod_t p);
    psum_t b;
    psum_t s;
    b = psum_t'(p);
    s = a + b;
    if (a[PSUM_W-1] == b[PSUM_W-1] && s[PSUM_W-1] != a[PSUM_W-1]) begin
      s = a[PSUM_W-1] ? {1'b1, {(PSUM_W-1){1'b0}}} : {1'b0, {(PSUM_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ----- rtl/mtc_mac.sv -----
// ============================================================================
// mtc_mac
// Registered signed multiplier shared by all lag updates.
// ============================================================================
module mtc_mac
  import mtc_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  sample_t a,
  input  sample_t b,
  output prod_t   p
);

  // one product per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      p <= prod_t'(a) * prod_t'(b);
    end
  end

endmodule

// ----- rtl/mtc_div.sv -----
// ============================================================================
// mtc_div
// Restoring divider, one quotient bit per cycle (64 by 32 bits).
// ============================================================================
module mtc_div
  import mtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PSUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [PSUM_W-1:0] quotient
);

  logic [CNT_W:0]   rem;
  logic [CNT_W-1:0] dvs;
  logic [6:0]       cnt;
  logic             run;
  logic [CNT_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem[CNT_W-1:0], quotient[PSUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  // shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        rem      <= ge ? rem_sh - {1'b0, dvs} : rem_sh;
        quotient <= {quotient[PSUM_W-2:0], ge};
        cnt      <= cnt + 7'd1;
        if (cnt == 7'(PSUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/multi_tau_correlator.sv -----
// ============================================================================
// multi_tau_correlator
// Multiple-tau auto/cross correlator with lag readout.
// ============================================================================
//  channel   signals                                   rule
//  command   start, busy, operation, sample_a/b,       taken when start & !busy
//            level, lag
//  result    done, mean_product, pair_count,           one cycle, no stall
//            lag_time, level_in_use
//  config    cfg_we, cfg_index, cfg_data               taken when cfg_we
//
// After reset a clearing pass over all 320 slots zeroes the stores; busy is high.
// A sample runs S_LVL and S_LEND per level, S_LRD, S_LMUL and, for a valid
// slot, S_LACC per lag slot on the one multiplier; it cascades upward.
// A read holds busy through S_QRD, S_QDIV and S_OUT, plus S_QWAIT while the
// divider runs; the result follows in the next cycle.
// The result strobe done lasts one cycle; the receiver cannot stall it.
module multi_tau_correlator
  import mtc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                operation,
  input  sample_t             sample_a,
  input  sample_t             sample_b,
  input  logic [LEVEL_W-1:0]  level,
  input  logic [LAG_W-1:0]    lag,
  output logic                done,
  output logic signed [MEAN_W-1:0] mean_product,
  output logic [CNT_W-1:0]    pair_count,
  output logic [TIME_W-1:0]   lag_time,
  output logic                level_in_use,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [1:0]          cfg_data
);

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LVL   = 11'b00000000100,
    S_LRD   = 11'b00000001000,
    S_LMUL  = 11'b00000010000,
    S_LACC  = 11'b00000100000,
    S_LEND  = 11'b00001000000,
    S_QRD   = 11'b00010000000,
    S_QDIV  = 11'b00100000000,
    S_QWAIT = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;

  logic       mode;
  logic [1:0] avg_shift;
  logic [1:0] sh;

  // memories
  sample_t          ring_a_mem [0:SLOTS-1];
  sample_t          ring_b_mem [0:SLOTS-1];
  logic             valid_mem  [0:SLOTS-1];
  psum_t            sum_mem    [0:SLOTS-1];
  logic [CNT_W-1:0] cnt_mem    [0:SLOTS-1];

  // per-level registers
  logic signed [LSUM_W-1:0] lsum_a [LEVELS];
  logic signed [LSUM_W-1:0] lsum_b [LEVELS];
  logic [LAG_W-1:0]         fill   [LEVELS];
  logic [LAG_W-1:0]         wp     [LEVELS];
  logic [LEVEL_W-1:0]       highest;

  logic [ADDR_W-1:0]  clr_idx;
  logic [LEVEL_W-1:0] k;
  logic [LAG_W-1:0]   j;
  sample_t            cur_a, cur_b, nxt_a, nxt_b;
  logic               pass;

  logic [LEVEL_W-1:0] lvl_q;
  logic [LAG_W-1:0]   lag_q;
  logic               oor;

  // read data
  sample_t          ra_q, rb_q;
  logic             rv_q;
  psum_t            sum_q;
  logic [CNT_W-1:0] cnt_q;

  // addresses and enables
  logic [ADDR_W-1:0] ring_addr, pc_addr;
  logic              ring_we, ring_re, pc_we, pc_re;
  sample_t           ring_wa, ring_wb;
  logic              ring_wv;
  psum_t             pc_wsum;
  logic [CNT_W-1:0]  pc_wcnt;

  prod_t             prod;
  logic              mac_en;
  logic              div_start, div_done;
  logic [PSUM_W-1:0] div_q, mag;

  logic signed [LSUM_W-1:0] sa_new, sb_new;
  logic [LAG_W-1:0]         fill_new;
  logic [LAG_W:0]           m_val;
  logic [LAG_W-1:0]         first_lag;
  logic                     last_lag;

  assign busy      = (state != S_IDLE);
  assign sh        = (avg_shift == 2'd0) ? 2'd1 : avg_shift;
  assign m_val     = (LAG_W+1)'(1) << sh;
  assign first_lag = LAG_W'(LAGS >> sh);
  assign last_lag  = (j == LAG_W'(LAGS - 1));
  assign oor       = lvl_q >= LEVEL_W'(LEVELS);

  assign sa_new   = lsum_a[k] + LSUM_W'(cur_a);
  assign sb_new   = lsum_b[k] + LSUM_W'(cur_b);
  assign fill_new = fill[k] + LAG_W'(1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      avg_shift <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:      mode      <= cfg_data[0];
        CFG_AVG_SHIFT: avg_shift <= cfg_data;
        default:       ;
      endcase
    end
  end

  // memory port control
  always_comb begin
    ring_addr = {k, wp[k] - j};
    pc_addr   = {k, j};
    ring_we   = 1'b0;
    ring_re   = 1'b0;
    pc_we     = 1'b0;
    pc_re     = 1'b0;
    ring_wa   = cur_a;
    ring_wb   = cur_b;
    ring_wv   = 1'b1;
    pc_wsum   = sat_add(sum_q, prod);
    pc_wcnt   = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
    unique case (state)
      S_CLR: begin
        ring_addr = clr_idx;
        pc_addr   = clr_idx;
        ring_we   = 1'b1;
        pc_we     = 1'b1;
        ring_wa   = '0;
        ring_wb   = '0;
        ring_wv   = 1'b0;
        pc_wsum   = '0;
        pc_wcnt   = '0;
      end
      S_LVL: begin
        ring_addr = {k, wp[k]};
        ring_we   = 1'b1;
      end
      S_LRD: begin
        ring_re = 1'b1;
        pc_re   = 1'b1;
      end
      S_LACC: pc_we = 1'b1;
      S_QRD: begin
        pc_addr = {lvl_q, lag_q};
        pc_re   = !oor;
      end
      default: ;
    endcase
  end

  // ring store
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_a_mem[ring_addr] <= ring_wa;
      ring_b_mem[ring_addr] <= ring_wb;
      valid_mem[ring_addr]  <= ring_wv;
    end
    if (ring_re) begin
      ra_q <= ring_a_mem[ring_addr];
      rb_q <= ring_b_mem[ring_addr];
      rv_q <= valid_mem[ring_addr];
    end
  end

  // product sum and count store
  always_ff @(posedge clk) begin
    if (pc_we) begin
      sum_mem[pc_addr] <= pc_wsum;
      cnt_mem[pc_addr] <= pc_wcnt;
    end
    if (pc_re) begin
      sum_q <= sum_mem[pc_addr];
      cnt_q <= cnt_mem[pc_addr];
    end
  end

  assign mac_en = (state == S_LMUL) && rv_q;

  mtc_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (cur_a),
    .b   (mode ? rb_q : ra_q),
    .p   (prod)
  );

  assign mag       = sum_q[PSUM_W-1] ? (~sum_q + PSUM_W'(1)) : sum_q;
  assign div_start = (state == S_QDIV) && !oor && (cnt_q != '0);

  mtc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (cnt_q),
    .done     (div_done),
    .quotient (div_q)
  );

  // result formatting
  logic [PSUM_W-1:0]  q_eff, q_sat;
  logic [6:0]         shamt;
  logic [67:0]        t_wide;
  logic [TIME_W-1:0]  t_val;
  logic signed [MEAN_W-1:0] mean_val;

  always_comb begin
    q_eff = (cnt_q == '0) ? '0 : div_q;
    if (sum_q[PSUM_W-1]) begin
      q_sat    = (q_eff > (PSUM_W'(1) << (MEAN_W-1))) ? (PSUM_W'(1) << (MEAN_W-1)) : q_eff;
      mean_val = MEAN_W'(~q_sat + PSUM_W'(1));
    end else begin
      q_sat    = (q_eff > ((PSUM_W'(1) << (MEAN_W-1)) - PSUM_W'(1)))
               ? ((PSUM_W'(1) << (MEAN_W-1)) - PSUM_W'(1)) : q_eff;
      mean_val = MEAN_W'(q_sat);
    end
    shamt  = 7'(sh) * 7'(lvl_q);
    t_wide = 68'(lag_q) << shamt[5:0];
    if (lag_q == '0) begin
      t_val = '0;
    end else if (shamt >= 7'(TIME_W)) begin
      t_val = '1;
    end else if (t_wide[67:TIME_W] != '0) begin
      t_val = '1;
    end else begin
      t_val = t_wide[TIME_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_idx <= '0;
      highest <= '0;
      done    <= 1'b0;
      k       <= '0;
      j       <= '0;
      pass    <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        lsum_a[i] <= '0;
        lsum_b[i] <= '0;
        fill[i]   <= '0;
        wp[i]     <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + ADDR_W'(1);
          if (clr_idx == ADDR_W'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            lvl_q <= level;
            lag_q <= lag;
            cur_a <= sample_a;
            cur_b <= sample_b;
            k     <= '0;
            state <= (operation == OP_READ) ? S_QRD : S_LVL;
          end
        end
        S_LVL: begin
          if (k > highest) highest <= k;
          if ({1'b0, fill_new} >= m_val) begin
            nxt_a     <= SAMPLE_WIDTH'(sa_new >>> sh);
            nxt_b     <= SAMPLE_WIDTH'(sb_new >>> sh);
            lsum_a[k] <= '0;
            lsum_b[k] <= '0;
            fill[k]   <= '0;
            pass      <= 1'b1;
          end else begin
            lsum_a[k] <= sa_new;
            lsum_b[k] <= sb_new;
            fill[k]   <= fill_new;
            pass      <= 1'b0;
          end
          j     <= (k == '0) ? '0 : first_lag;
          state <= S_LRD;
        end
        S_LRD: state <= S_LMUL;
        S_LMUL: begin
          if (rv_q) begin
            state <= S_LACC;
          end else if (last_lag) begin
            state <= S_LEND;
          end else begin
            j     <= j + LAG_W'(1);
            state <= S_LRD;
          end
        end
        S_LACC: begin
          if (last_lag) begin
            state <= S_LEND;
          end else begin
            j     <= j + LAG_W'(1);
            state <= S_LRD;
          end
        end
        S_LEND: begin
          wp[k] <= wp[k] + LAG_W'(1);
          if (pass && k != LEVEL_W'(LEVELS - 1)) begin
            k     <= k + LEVEL_W'(1);
            cur_a <= nxt_a;
            cur_b <= nxt_b;
            state <= S_LVL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_QRD: state <= S_QDIV;
        S_QDIV: state <= div_start ? S_QWAIT : S_OUT;
        S_QWAIT: if (div_done) state <= S_OUT;
        S_OUT: begin
          done <= 1'b1;
          if (oor) begin
            mean_product <= '0;
            pair_count   <= '0;
            lag_time     <= '0;
            level_in_use <= 1'b0;
          end else begin
            mean_product <= mean_val;
            pair_count   <= cnt_q;
            lag_time     <= t_val;
            level_in_use <= (lvl_q == '0) || (lvl_q < highest);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mtc_checker.sv -----
// ============================================================================
// mtc_checker
// Port-level checks of the correlator's command and result timing.
// ============================================================================
module mtc_checker
  import mtc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     operation,
  input logic                     done,
  input logic signed [MEAN_W-1:0] mean_product,
  input logic [CNT_W-1:0]         pair_count
);

  // a result only appears while idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted transaction makes the block busy
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a sample produces no result
  a_sample_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_SAMPLE) |=> !done)
    else $error("result after sample transaction");

  // an empty lag reads as zero mean
  a_zero_mean: assert property (@(posedge clk) disable iff (rst)
    (done && pair_count == '0) |-> mean_product == '0)
    else $error("nonzero mean with zero count");

endmodule

bind multi_tau_correlator mtc_checker u_mtc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .operation    (operation),
  .done         (done),
  .mean_product (mean_product),
  .pair_count   (pair_count)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multiple-tau correlator. A queue-fed driver
// sends sample and read transactions with random gaps; a local predictor
// tracks the rings, level averaging and lag sums. The monitor compares every
// read result against the oldest predicted result. Configuration changes are
// made between phases, only once the block has gone idle.
// ----------------------------------------------------------------------------
module tb_top;
  import mtc_pkg::*;

  localparam int  WDOG_LIMIT  = 20000;
  localparam int  SETTLE_CYC  = 1200;
  localparam longint MAX_SUM  = 64'sh7fff_ffff_ffff_ffff;
  localparam longint MIN_SUM  = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] MAX_TIME = (64'd1 << TIME_W) - 64'd1;

  typedef struct {
    logic               op;
    sample_t            a;
    sample_t            b;
    logic [LEVEL_W-1:0] lvl;
    logic [LAG_W-1:0]   lg;
  } cmd_t;

  typedef struct {
    logic signed [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]         cnt;
    logic [TIME_W-1:0]        tau;
    logic                     in_use;
  } lag_rpt_t;

  // DUT ports
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     operation = OP_SAMPLE;
  sample_t                  sample_a = '0;
  sample_t                  sample_b = '0;
  logic [LEVEL_W-1:0]       level = '0;
  logic [LAG_W-1:0]         lag = '0;
  logic                     done;
  logic signed [MEAN_W-1:0] mean_product;
  logic [CNT_W-1:0]         pair_count;
  logic [TIME_W-1:0]        lag_time;
  logic                     level_in_use;
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = CFG_MODE;
  logic [1:0]               cfg_data = '0;

  multi_tau_correlator u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // correlator shadow state
  logic       xmode;
  logic [1:0] shift_reg;
  longint     ring_a  [SLOTS];
  longint     ring_b  [SLOTS];
  bit         filled  [SLOTS];
  longint     lag_sum [SLOTS];
  int unsigned lag_cnt [SLOTS];
  longint     acc_a   [LEVELS];
  longint     acc_b   [LEVELS];
  int         fill_n  [LEVELS];
  int         wr_ptr  [LEVELS];
  int         top_level;

  cmd_t     pend_cmds[$];
  lag_rpt_t pend_rpts[$];
  int       errors = 0;
  bit       no_gaps = 1'b0;

  function automatic int shift_amt();
    return (shift_reg == 2'd0) ? 1 : int'(shift_reg);
  endfunction

  function automatic longint sum_sat(longint acc, longint p);
    longint s;
    s = acc + p;
    if (acc[63] == p[63] && s[63] != acc[63]) s = acc[63] ? MIN_SUM : MAX_SUM;
    return s;
  endfunction

  // push one sample through the level cascade
  task automatic push_sample(longint va, longint vb);
    int s, first, base, wp, idx;
    bit pass;
    longint na, nb, partner;
    s = shift_amt();
    first = LAGS >> s;
    for (int k = 0; k < LEVELS; k++) begin
      base = k * LAGS;
      wp = wr_ptr[k];
      pass = 1'b0;
      if (k > top_level) top_level = k;
      ring_a[base + wp] = va;
      ring_b[base + wp] = vb;
      filled[base + wp] = 1'b1;
      acc_a[k] += va;
      acc_b[k] += vb;
      fill_n[k]++;
      if (fill_n[k] >= (1 << s)) begin
        na = acc_a[k] >>> s;
        nb = acc_b[k] >>> s;
        acc_a[k] = 0;
        acc_b[k] = 0;
        fill_n[k] = 0;
        pass = 1'b1;
      end
      for (int j = (k == 0) ? 0 : first; j < LAGS; j++) begin
        idx = base + (wp + LAGS - j) % LAGS;
        if (filled[idx]) begin
          partner = xmode ? ring_b[idx] : ring_a[idx];
          lag_sum[base + j] = sum_sat(lag_sum[base + j], va * partner);
          if (lag_cnt[base + j] != 32'hffff_ffff) lag_cnt[base + j]++;
        end
      end
      wr_ptr[k] = (wp + 1) % LAGS;
      if (!pass) break;
      va = na;
      vb = nb;
    end
  endtask

  function automatic lag_rpt_t lag_report(int lvl, int lg);
    lag_rpt_t r;
    int idx, sh;
    longint sum;
    logic [63:0] mag, q, t;
    r.mean = '0;
    r.cnt = '0;
    r.tau = '0;
    r.in_use = 1'b0;
    if (lvl >= LEVELS || lg >= LAGS) return r;
    idx = lvl * LAGS + lg;
    sum = lag_sum[idx];
    if (lag_cnt[idx] != 0) begin
      mag = (sum < 0) ? 64'(-sum) : 64'(sum);
      q = mag / 64'(lag_cnt[idx]);
      if (sum < 0) begin
        if (q > (64'd1 << 47)) q = 64'd1 << 47;
        r.mean = -q[MEAN_W-1:0];
      end else begin
        if (q > (64'd1 << 47) - 1) q = (64'd1 << 47) - 1;
        r.mean = q[MEAN_W-1:0];
      end
    end
    r.cnt = lag_cnt[idx];
    sh = shift_amt() * lvl;
    if (lg == 0) t = '0;
    else if (sh >= 61) t = MAX_TIME;
    else begin
      t = 64'(lg) << sh;
      if ((t >> sh) != 64'(lg) || t > MAX_TIME) t = MAX_TIME;
    end
    r.tau = t[TIME_W-1:0];
    r.in_use = (lvl == 0 || lvl < top_level);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 100);
  endfunction

  // driver: one transaction per handshake, prediction at acceptance
  int gap_cnt = 0;
  always @(posedge clk) begin
    logic go;
    cmd_t c;
    go = start;
    if (!rst && start && !busy) begin
      go = 1'b0;
      if (operation == OP_SAMPLE) push_sample(longint'(sample_a), longint'(sample_b));
      else pend_rpts.push_back(lag_report(int'(level), int'(lag)));
      gap_cnt = pick_gap();
    end
    if (!rst && !go) begin
      if (gap_cnt > 0) gap_cnt--;
      else if (pend_cmds.size() > 0) begin
        c = pend_cmds.pop_front();
        operation <= c.op;
        sample_a  <= c.a;
        sample_b  <= c.b;
        level     <= c.lvl;
        lag       <= c.lg;
        go = 1'b1;
      end
    end
    start <= go;
  end

  // monitor: results cannot be stalled, check on every strobe
  always @(posedge clk) begin
    lag_rpt_t e;
    if (!rst && done) begin
      if (pend_rpts.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        errors++;
      end else begin
        e = pend_rpts.pop_front();
        if (mean_product !== e.mean) begin
          $display("%0t: mean_product exp %0d got %0d", $time, e.mean, mean_product);
          errors++;
        end
        if (pair_count !== e.cnt) begin
          $display("%0t: pair_count exp %0d got %0d", $time, e.cnt, pair_count);
          errors++;
        end
        if (lag_time !== e.tau) begin
          $display("%0t: lag_time exp %0d got %0d", $time, e.tau, lag_time);
          errors++;
        end
        if (level_in_use !== e.in_use) begin
          $display("%0t: level_in_use exp %0b got %0b", $time, e.in_use, level_in_use);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) quiet <= 0;
    else if (quiet >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else quiet <= quiet + 1;
  end

  function automatic cmd_t mk_sample(sample_t a, sample_t b);
    cmd_t c;
    c.op = OP_SAMPLE; c.a = a; c.b = b; c.lvl = '0; c.lg = '0;
    return c;
  endfunction

  function automatic cmd_t mk_read(int lvl, int lg);
    cmd_t c;
    c.op = OP_READ; c.a = sample_t'($urandom); c.b = sample_t'($urandom);
    c.lvl = LEVEL_W'(lvl); c.lg = LAG_W'(lg);
    return c;
  endfunction

  function automatic sample_t rnd_sample();
    case ($urandom_range(0, 9))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return sample_t'($urandom_range(0, 7)) - 24'sd3;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // hold until no transaction is pending and the block has settled
  task automatic wait_idle();
    @(posedge clk);
    while (pend_cmds.size() != 0 || start || pend_rpts.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_MODE) xmode = val[0];
    else shift_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [2:0] phase_cfg [6];
    xmode = 1'b0;
    shift_reg = 2'd1;
    foreach (ring_a[i]) begin
      ring_a[i] = 0; ring_b[i] = 0; filled[i] = 0; lag_sum[i] = 0; lag_cnt[i] = 0;
    end
    foreach (acc_a[i]) begin
      acc_a[i] = 0; acc_b[i] = 0; fill_n[i] = 0; wr_ptr[i] = 0;
    end
    top_level = 0;
    // {mode, avg_shift}; avg_shift of zero acts as one; the shift never
    // drops, so every level mean stays within the sample range
    phase_cfg = '{3'b0_01, 3'b1_00, 3'b0_10, 3'b1_10, 3'b0_11, 3'b1_11};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_MODE, {1'b0, phase_cfg[p][2]});
      write_cfg(CFG_AVG_SHIFT, phase_cfg[p][1:0]);
      no_gaps = (p == 2);
      if (p == 0) begin
        // field extremes, reads on every kind of slot
        pend_cmds.push_back(mk_sample(24'sh7fffff, 24'sh800000));
        pend_cmds.push_back(mk_sample(24'sh800000, 24'sh7fffff));
        pend_cmds.push_back(mk_sample(24'sh000000, 24'shffffff));
        pend_cmds.push_back(mk_sample(24'shffffff, 24'sh000000));
        pend_cmds.push_back(mk_sample(24'sh7fffff, 24'sh7fffff));
        pend_cmds.push_back(mk_sample(24'sh800000, 24'sh800000));
        for (int i = 0; i < 6; i++) pend_cmds.push_back(mk_sample(rnd_sample(), rnd_sample()));
        pend_cmds.push_back(mk_read(0, 0));
        pend_cmds.push_back(mk_read(0, 1));
        pend_cmds.push_back(mk_read(0, 15));
        pend_cmds.push_back(mk_read(1, 0));    // below first lag of upper level
        pend_cmds.push_back(mk_read(1, 12));
        pend_cmds.push_back(mk_read(2, 8));
        pend_cmds.push_back(mk_read(19, 15));
        pend_cmds.push_back(mk_read(20, 3));   // level past the last
        pend_cmds.push_back(mk_read(31, 15));
        pend_cmds.push_back(mk_read(3, 0));
      end
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 3) != 0)
          pend_cmds.push_back(mk_sample(rnd_sample(), rnd_sample()));
        else if ($urandom_range(0, 4) == 0)
          pend_cmds.push_back(mk_read($urandom_range(0, 31), $urandom_range(0, 15)));
        else
          pend_cmds.push_back(mk_read($urandom_range(0, 8), $urandom_range(0, 15)));
      end
      wait_idle();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- multi_tau_correlator.f -----
rtl/mtc_pkg.sv
rtl/mtc_mac.sv
rtl/mtc_div.sv
rtl/multi_tau_correlator.sv
rtl/mtc_checker.sv
bench/tb_top.sv
